@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on each rising edge, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/dkl_pkg.sv @@
// Types and constants of the debounced keypad code lock.
`default_nettype none
package dkl_pkg;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [3:0] key;
	} dkl_event_t;

	typedef enum logic [1:0] {
		PIC_BLANK = 2'd0,
		PIC_BOX   = 2'd1,
		PIC_HAPPY = 2'd2,
		PIC_SAD   = 2'd3
	} pic_t;

	typedef enum logic [2:0] {
		REG_CODE0    = 3'd0,
		REG_CODE1    = 3'd1,
		REG_CODE2    = 3'd2,
		REG_CODE3    = 3'd3,
		REG_DEBOUNCE = 3'd4,
		REG_BOX      = 3'd5,
		REG_RESULT   = 3'd6
	} reg_idx_t;

	localparam logic [2:0] MODE_IDLE       = 3'd0;
	localparam logic [2:0] MODE_ENTERING   = 3'd1;
	localparam logic [2:0] MODE_VALIDATING = 3'd2;
	localparam logic [2:0] MODE_GRANTED    = 3'd3;
	localparam logic [2:0] MODE_DENIED     = 3'd4;

	localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
	localparam logic [3:0] KEY_STAR       = 4'd10;

	localparam logic [7:0]  DEBOUNCE_MAX = 8'hFF;
	localparam logic [9:0]  BOX_MAX      = 10'h3FF;
	localparam logic [11:0] RESULT_MAX   = 12'hFFF;

endpackage
`default_nettype wire

@@ sv/dkl_debounce.sv @@
// Four-state key debouncer producing press and release events.
`default_nettype none
module dkl_debounce
	import dkl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       present,
	input  wire logic [3:0] key,
	input  wire logic [7:0] ticks,
	output dkl_event_t      ev
);

	typedef enum logic [3:0] {
		DB_IDLE         = 4'b0001,
		DB_PRESS_WAIT   = 4'b0010,
		DB_PRESSED      = 4'b0100,
		DB_RELEASE_WAIT = 4'b1000
	} db_state_t;

	db_state_t  state_q, state_d;
	logic [3:0] held_q, held_d;
	logic [7:0] elapsed_q, elapsed_d, elapsed_inc;

	assign elapsed_inc = (elapsed_q == DEBOUNCE_MAX) ? elapsed_q : elapsed_q + 8'd1;

	always_comb begin
		state_d   = state_q;
		held_d    = held_q;
		elapsed_d = elapsed_inc;
		ev.kind   = EV_NONE;
		ev.key    = 4'd0;
		case (state_q)
			DB_IDLE: begin
				if (present) begin
					held_d    = key;
					elapsed_d = 8'd0;
					state_d   = DB_PRESS_WAIT;
				end
			end
			DB_PRESS_WAIT: begin
				if (!present) begin
					state_d = DB_IDLE;
				end else if (elapsed_inc >= ticks) begin
					ev.kind = EV_PRESS;
					ev.key  = held_q;
					state_d = DB_PRESSED;
				end
			end
			DB_PRESSED: begin
				if (!present) begin
					elapsed_d = 8'd0;
					state_d   = DB_RELEASE_WAIT;
				end
			end
			DB_RELEASE_WAIT: begin
				if (present) begin
					state_d = DB_PRESSED;
				end else if (elapsed_inc >= ticks) begin
					ev.kind = EV_RELEASE;
					ev.key  = held_q;
					state_d = DB_IDLE;
				end
			end
			default: begin
				state_d = DB_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= DB_IDLE;
			held_q    <= 4'd0;
			elapsed_q <= 8'd0;
		end else if (en) begin
			state_q   <= state_d;
			held_q    <= held_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/debounced_keypad_code_lock_core.sv @@
// Top level: tick stream in, debounced key events and code lock status out.
//
//  channel | handshake               | payload
//  s_*     | s_tvalid / s_tready     | s_tdata[7:0]  tick: key state
//  m_*     | m_tvalid / m_tready     | m_tdata[15:0] result: event and lock status
//  cfg_*   | cfg_we (no wait)        | cfg_index[2:0], cfg_data[11:0]
//
// One tick per cycle sustained while m_tready stays high.
// A request sits in the input register, then debouncer and lock update as it
// moves into the result register, which only happens while that slot is free.
// A stalled m_tready backs up into s_tready once both registers are full.
// Reset clears control and timers; entry digits stay unknown until written.
`default_nettype none
module debounced_keypad_code_lock_core
	import dkl_pkg::*;
#(
	parameter int CODE_LENGTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] key_present, [4:1] key_value, [7:5] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [1:0] key_event, [5:2] event_key,
	                                    // [8:6] lock_mode, [10:9] display_pattern,
	                                    // [13:11] digits_entered, [15:14] zero
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);

	localparam int CW = $clog2(CODE_LENGTH + 1);
	localparam int IW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

	typedef enum logic [4:0] {
		LK_IDLE       = 5'b00001,
		LK_ENTERING   = 5'b00010,
		LK_VALIDATING = 5'b00100,
		LK_GRANTED    = 5'b01000,
		LK_DENIED     = 5'b10000
	} lk_state_t;

	// configuration
	logic [3:0]  code_q [4];
	logic [7:0]  db_ticks_q;
	logic [9:0]  box_ticks_q;
	logic [11:0] res_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q[0]   <= 4'd8;
			code_q[1]   <= 4'd3;
			code_q[2]   <= 4'd1;
			code_q[3]   <= 4'd4;
			db_ticks_q  <= 8'd20;
			box_ticks_q <= 10'd300;
			res_ticks_q <= 12'd2000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CODE0:    code_q[0]   <= cfg_data[3:0];
				REG_CODE1:    code_q[1]   <= cfg_data[3:0];
				REG_CODE2:    code_q[2]   <= cfg_data[3:0];
				REG_CODE3:    code_q[3]   <= cfg_data[3:0];
				REG_DEBOUNCE: db_ticks_q  <= cfg_data[7:0];
				REG_BOX:      box_ticks_q <= cfg_data[9:0];
				REG_RESULT:   res_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register and handshake
	logic       valid_s1;
	logic       present_s1;
	logic [3:0] key_s1;
	logic       advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			present_s1 <= s_tdata[0];
			key_s1     <= s_tdata[4:1];
		end
	end

	dkl_event_t ev;

	dkl_debounce u_debounce (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.present (present_s1),
		.key     (key_s1),
		.ticks   (db_ticks_q),
		.ev      (ev)
	);

	// code lock
	lk_state_t     phase_q, phase_d;
	pic_t          pic_q, pic_d;
	logic [CW-1:0] count_q, count_d;
	logic [9:0]    box_q, box_d, box_inc;
	logic [11:0]   res_q, res_d, res_inc;
	logic [3:0]    entry_q [CODE_LENGTH];
	logic          entry_we;
	logic [IW-1:0] entry_idx;
	logic          press, digit, star, match;

	assign box_inc = (box_q == BOX_MAX) ? box_q : box_q + 10'd1;
	assign res_inc = (res_q == RESULT_MAX) ? res_q : res_q + 12'd1;
	assign press   = (ev.kind == EV_PRESS);
	assign digit   = press && (ev.key <= KEY_LAST_DIGIT);
	assign star    = press && (ev.key == KEY_STAR);

	always_comb begin
		match = 1'b1;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			if (entry_q[i] != code_q[i % 4]) match = 1'b0;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		pic_d     = pic_q;
		count_d   = count_q;
		box_d     = box_inc;
		res_d     = res_inc;
		entry_we  = 1'b0;
		entry_idx = '0;
		case (phase_q)
			LK_IDLE: begin
				if (digit) begin
					entry_we = 1'b1;
					count_d  = CW'(1);
					pic_d    = PIC_BOX;
					box_d    = 10'd0;
					phase_d  = LK_ENTERING;
				end else if (star) begin
					count_d = '0;
					pic_d   = PIC_BLANK;
					phase_d = LK_IDLE;
				end
			end
			LK_ENTERING: begin
				if (box_inc >= box_ticks_q) pic_d = PIC_BLANK;
				if (star) begin
					count_d = '0;
					pic_d   = PIC_BLANK;
					phase_d = LK_IDLE;
				end else if (digit) begin
					if (count_q < CW'(CODE_LENGTH)) begin
						entry_we  = 1'b1;
						entry_idx = count_q[IW-1:0];
						count_d   = count_q + CW'(1);
						pic_d     = PIC_BOX;
						box_d     = 10'd0;
					end
					if (count_d >= CW'(CODE_LENGTH)) phase_d = LK_VALIDATING;
				end
			end
			LK_VALIDATING: begin
				if (box_inc >= box_ticks_q) begin
					if (match) begin
						pic_d   = PIC_HAPPY;
						phase_d = LK_GRANTED;
					end else begin
						pic_d   = PIC_SAD;
						phase_d = LK_DENIED;
					end
					res_d = 12'd0;
				end
			end
			LK_GRANTED, LK_DENIED: begin
				if (res_inc >= res_ticks_q) begin
					count_d = '0;
					pic_d   = PIC_BLANK;
					phase_d = LK_IDLE;
				end
			end
			default: begin
				phase_d = LK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= LK_IDLE;
			pic_q   <= PIC_BLANK;
			count_q <= '0;
			box_q   <= 10'd0;
			res_q   <= 12'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			pic_q   <= pic_d;
			count_q <= count_d;
			box_q   <= box_d;
			res_q   <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && entry_we) entry_q[entry_idx] <= ev.key;
	end

	logic [2:0] mode_d;

	always_comb begin
		case (phase_d)
			LK_IDLE:       mode_d = MODE_IDLE;
			LK_ENTERING:   mode_d = MODE_ENTERING;
			LK_VALIDATING: mode_d = MODE_VALIDATING;
			LK_GRANTED:    mode_d = MODE_GRANTED;
			LK_DENIED:     mode_d = MODE_DENIED;
			default:       mode_d = MODE_IDLE;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {2'b00, 3'(count_d), pic_d, mode_d, ev.key, ev.kind};
		end
	end

endmodule
`default_nettype wire

@@ sv/dkl_checker.sv @@
// Port-level checks of the code lock core, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module dkl_checker
	import dkl_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	`ASSERT_CLK(a_stall_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
	`ASSERT_NEVER(a_idle_key, clk, arst_n, m_tvalid && m_tdata[1:0] == EV_NONE && m_tdata[5:2] != 4'd0, "key reported without an event")
	`ASSERT_NEVER(a_happy_mode, clk, arst_n, m_tvalid && m_tdata[10:9] == PIC_HAPPY && m_tdata[8:6] != MODE_GRANTED, "happy picture outside granted")
	`ASSERT_NEVER(a_idle_count, clk, arst_n, m_tvalid && m_tdata[8:6] == MODE_IDLE && m_tdata[13:11] != 3'd0, "digits kept while idle")

endmodule

bind debounced_keypad_code_lock_core dkl_checker u_dkl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

@@ tb/sv/debounced_keypad_code_lock_core_tb.sv @@
// Testbench for the keypad code lock core: tick stream stimulus checked against a local model.
module debounced_keypad_code_lock_core_tb;
	import dkl_pkg::*;

	localparam int ENTRY_LEN   = 4;
	localparam int CYCLE_LIMIT = 2_000_000;

	localparam logic [3:0] KEY_HASH     = 4'd11;
	localparam logic [3:0] KEY_LETTER_A = 4'd12;
	localparam logic [3:0] KEY_LETTER_D = 4'd15;

	typedef enum logic [1:0] {
		KB_UP,
		KB_SETTLING_DOWN,
		KB_DOWN,
		KB_SETTLING_UP
	} key_phase_t;

	typedef struct packed {
		ev_kind_t   ev;
		logic [3:0] key;
		logic [2:0] mode;
		pic_t       pic;
		logic [2:0] digits;
	} tick_status_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [0] key_present, [4:1] key_value, [7:5] zero
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;          // [1:0] key_event, [5:2] event_key, [8:6] lock_mode,
	                               // [10:9] display_pattern, [13:11] digits_entered
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [11:0] cfg_data  = '0;

	// lock settings as last written
	logic [3:0]  cfg_code [ENTRY_LEN] = '{4'd8, 4'd3, 4'd1, 4'd4};
	logic [7:0]  cfg_debounce = 8'd20;
	logic [9:0]  cfg_box      = 10'd300;
	logic [11:0] cfg_result   = 12'd2000;

	// model state
	key_phase_t  kb_state     = KB_UP;
	logic [3:0]  latched_key  = '0;
	logic [7:0]  deb_elapsed  = '0;
	logic [2:0]  lock_mode    = MODE_IDLE;
	logic [3:0]  entry [ENTRY_LEN] = '{4'd0, 4'd0, 4'd0, 4'd0};
	logic [2:0]  digit_count  = '0;
	logic [9:0]  box_elapsed  = '0;
	logic [11:0] res_elapsed  = '0;
	pic_t        pic          = PIC_BLANK;

	tick_status_t pending_status [$];
	int           mismatches = 0;
	int           ticks_sent = 0;
	int           hold_req   = 0;
	bit           no_gaps    = 1'b0;

	debounced_keypad_code_lock_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void clear_entry();
		digit_count = '0;
		pic = PIC_BLANK;
		lock_mode = MODE_IDLE;
	endfunction

	function automatic tick_status_t advance_tick(input logic present, input logic [3:0] key);
		tick_status_t r;
		bit pressed_now, is_digit, is_star, matched;
		r.ev = EV_NONE;
		r.key = '0;
		if (deb_elapsed != DEBOUNCE_MAX) deb_elapsed++;
		if (box_elapsed != BOX_MAX) box_elapsed++;
		if (res_elapsed != RESULT_MAX) res_elapsed++;

		case (kb_state)
			KB_UP: if (present) begin
				latched_key = key;
				deb_elapsed = '0;
				kb_state = KB_SETTLING_DOWN;
			end
			KB_SETTLING_DOWN: if (!present) begin
				kb_state = KB_UP;
			end else if (deb_elapsed >= cfg_debounce) begin
				r.ev = EV_PRESS;
				r.key = latched_key;
				kb_state = KB_DOWN;
			end
			KB_DOWN: if (!present) begin
				deb_elapsed = '0;
				kb_state = KB_SETTLING_UP;
			end
			default: if (present) begin
				kb_state = KB_DOWN;
			end else if (deb_elapsed >= cfg_debounce) begin
				r.ev = EV_RELEASE;
				r.key = latched_key;
				kb_state = KB_UP;
			end
		endcase

		pressed_now = (r.ev == EV_PRESS);
		is_digit = pressed_now && r.key <= KEY_LAST_DIGIT;
		is_star = pressed_now && r.key == KEY_STAR;

		case (lock_mode)
			MODE_IDLE: if (is_digit) begin
				entry[0] = r.key;
				digit_count = 3'd1;
				pic = PIC_BOX;
				box_elapsed = '0;
				lock_mode = MODE_ENTERING;
			end else if (is_star) begin
				clear_entry();
			end
			MODE_ENTERING: begin
				if (box_elapsed >= cfg_box) pic = PIC_BLANK;
				if (is_star) begin
					clear_entry();
				end else if (is_digit) begin
					if (digit_count < ENTRY_LEN) begin
						entry[digit_count[1:0]] = r.key;
						digit_count++;
						pic = PIC_BOX;
						box_elapsed = '0;
					end
					if (digit_count >= ENTRY_LEN) lock_mode = MODE_VALIDATING;
				end
			end
			MODE_VALIDATING: if (box_elapsed >= cfg_box) begin
				matched = 1'b1;
				for (int i = 0; i < ENTRY_LEN; i++)
					if (entry[i] != cfg_code[i % 4]) matched = 1'b0;
				if (matched) begin
					pic = PIC_HAPPY;
					lock_mode = MODE_GRANTED;
				end else begin
					pic = PIC_SAD;
					lock_mode = MODE_DENIED;
				end
				res_elapsed = '0;
			end
			default: if (res_elapsed >= cfg_result) begin
				clear_entry();
			end
		endcase

		r.mode = lock_mode;
		r.pic = pic;
		r.digits = digit_count;
		return r;
	endfunction

	function automatic int gap_length();
		int roll;
		if (no_gaps) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// shortest steady run that yields an event
	function automatic int settle();
		return (cfg_debounce == 0) ? 2 : int'(cfg_debounce) + 1;
	endfunction

	task automatic send_tick(input logic present, input logic [3:0] key);
		int gap;
		logic ready_seen;
		gap = gap_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, key, present};
		do begin
			@(negedge clk);
			ready_seen = s_tready;
			@(posedge clk);
		end while (!ready_seen);
		pending_status.push_back(advance_tick(present, key));
		ticks_sent++;
	endtask

	task automatic idle_ticks(input int n);
		repeat (n) send_tick(1'b0, 4'($urandom_range(0, 15)));
	endtask

	task automatic tap_key(input logic [3:0] key, input int hold, input int rel, input bit wobble);
		send_tick(1'b1, key);
		for (int i = 1; i < hold; i++)
			send_tick(1'b1, wobble ? 4'($urandom_range(0, 15)) : key);
		idle_ticks(rel);
	endtask

	task automatic tap(input logic [3:0] key);
		tap_key(key, settle(), settle(), 1'b0);
	endtask

	// digits go in lowest nibble first, then the lock runs to its result and back
	task automatic enter_code(input logic [15:0] code_word);
		for (int i = 0; i < ENTRY_LEN; i++) tap(code_word[4*i +: 4]);
		idle_ticks(int'(cfg_box) + int'(cfg_result) + 4);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [11:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CODE0, REG_CODE1, REG_CODE2, REG_CODE3: cfg_code[idx[1:0]] = value[3:0];
			REG_DEBOUNCE: cfg_debounce = value[7:0];
			REG_BOX: cfg_box = value[9:0];
			REG_RESULT: cfg_result = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_code(input logic [15:0] code_word);
		for (int i = 0; i < ENTRY_LEN; i++)
			write_reg(reg_idx_t'(int'(REG_CODE0) + i),
				(12'($urandom) & 12'hFF0) | 12'(code_word[4*i +: 4]));
	endtask

	task automatic set_timers(input int deb, input int box, input int res);
		write_reg(REG_DEBOUNCE, (12'($urandom) & 12'hF00) | 12'(deb));
		write_reg(REG_BOX, (12'($urandom) & 12'hC00) | 12'(box));
		write_reg(REG_RESULT, 12'(res));
	endtask

	task automatic test_reset_defaults();
		logic [15:0] code_word;
		code_word = {4'd4, 4'd1, 4'd3, 4'd8};
		for (int i = 0; i < ENTRY_LEN; i++) tap(code_word[4*i +: 4]);
		// short timers let the verdict come soon
		set_timers(2, 3, 4);
		idle_ticks(int'(cfg_box) + int'(cfg_result) + 4);
	endtask

	task automatic test_bounce();
		set_timers(2, 3, 4);
		tap_key(4'd5, 1, 3, 1'b0);
		tap_key(4'd5, 2, 3, 1'b0);
		// release interrupted by a short press
		tap_key(4'd5, 5, 1, 1'b0);
		tap_key(4'd5, 2, 4, 1'b0);
		tap(KEY_STAR);
	endtask

	task automatic test_latched_key();
		tap_key(4'd7, settle() + 3, settle(), 1'b1);
		tap_key(4'd15, settle() + 2, settle(), 1'b1);
		tap(KEY_STAR);
	endtask

	task automatic test_special_keys();
		set_timers(2, 20, 30);
		tap(KEY_HASH);
		for (int k = KEY_LETTER_A; k <= KEY_LETTER_D; k++) tap(4'(k));
		tap(4'd2);
		tap(KEY_HASH);
		tap(4'd6);
		tap(KEY_STAR);
		for (int k = 1; k <= ENTRY_LEN; k++) tap(4'(k));
		// digits and star while validating, then while the result shows
		tap(4'd5);
		tap(KEY_STAR);
		tap(4'd9);
		tap(KEY_STAR);
		idle_ticks(60);
		set_timers(2, 3, 4);
	endtask

	task automatic test_code_match();
		set_code({4'd0, 4'd9, 4'd0, 4'd9});
		enter_code({4'd0, 4'd9, 4'd0, 4'd9});
		enter_code({4'd1, 4'd9, 4'd0, 4'd9});
		// code digit above nine never matches
		write_reg(REG_CODE3, 12'hFFF);
		enter_code({4'd15, 4'd9, 4'd0, 4'd9});
		enter_code({4'd9, 4'd9, 4'd0, 4'd9});
		set_code({4'd4, 4'd1, 4'd3, 4'd8});
	endtask

	task automatic test_zero_timers();
		set_timers(0, 0, 0);
		enter_code({4'd6, 4'd5, 4'd2, 4'd7});
		enter_code({4'd4, 4'd1, 4'd3, 4'd8});
		tap(KEY_STAR);
		tap(4'd3);
		tap(KEY_STAR);
		idle_ticks(3);
	endtask

	task automatic test_max_timers();
		set_timers(255, 1023, 4095);
		// held well short of the debounce window
		tap_key(4'd8, 40, 5, 1'b0);
		write_reg(REG_DEBOUNCE, 12'd1);
		tap(4'd8);
		tap(4'd3);
		tap(4'd1);
		tap(4'd4);
		set_timers(1, 3, 4);
		idle_ticks(int'(cfg_box) + int'(cfg_result) + 4);
	endtask

	task automatic test_backpressure();
		set_timers(2, 3, 4);
		no_gaps = 1'b1;
		hold_req = 200;
		tap(4'd1);
		tap(4'd2);
		tap(KEY_STAR);
		wait_drained();
		no_gaps = 1'b0;
	endtask

	task automatic test_random();
		int start_ticks, roll, hold, rel;
		logic [3:0] d;
		logic [15:0] code_word;
		start_ticks = ticks_sent;
		while (ticks_sent - start_ticks < 80) begin
			if ($urandom_range(0, 5) == 0) begin
				for (int i = 0; i < ENTRY_LEN; i++)
					code_word[4*i +: 4] = ($urandom_range(0, 9) == 0) ?
						4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
				set_code(code_word);
				set_timers($urandom_range(0, 4), $urandom_range(0, 8), $urandom_range(0, 8));
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				for (int i = 0; i < ENTRY_LEN; i++) begin
					roll = $urandom_range(0, 99);
					if (roll < 6) tap(KEY_STAR);
					else if (roll < 12) tap(4'($urandom_range(11, 15)));
					d = ($urandom_range(0, 1) && cfg_code[i] <= KEY_LAST_DIGIT) ?
						cfg_code[i] : 4'($urandom_range(0, 9));
					hold = ($urandom_range(0, 9) == 0) ?
						$urandom_range(1, settle() - 1) : settle() + $urandom_range(0, 2);
					rel = ($urandom_range(0, 9) == 0) ? 1 : settle() + $urandom_range(0, 2);
					tap_key(d, hold, rel, $urandom_range(0, 4) == 0);
				end
				idle_ticks($urandom_range(0, int'(cfg_box) + int'(cfg_result) + 4));
			end else if (roll < 90) begin
				repeat ($urandom_range(1, 12))
					send_tick(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
			end else if (roll < 96) begin
				hold_req = $urandom_range(20, 80);
			end else begin
				wait_drained();
			end
		end
		no_gaps = 1'b0;
	endtask

	// receiver: random stalls plus requested long hold-offs
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				m_tready <= 1'b0;
				hold_req--;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				stall = gap_length();
			end
		end
	end

	// all inputs change at the rising edge, so the negedge sees what the next edge takes
	always @(negedge clk) begin : check_result
		tick_status_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.ev = ev_kind_t'(m_tdata[1:0]);
			got.key = m_tdata[5:2];
			got.mode = m_tdata[8:6];
			got.pic = pic_t'(m_tdata[10:9]);
			got.digits = m_tdata[13:11];
			if (pending_status.size() == 0) begin
				if (mismatches < 10) $display("result with no pending request: %h", m_tdata);
				mismatches++;
			end else begin
				want = pending_status.pop_front();
				if (got.ev !== want.ev || got.key !== want.key || got.mode !== want.mode ||
				    got.pic !== want.pic || got.digits !== want.digits) begin
					if (mismatches < 10)
						$display("status: expected ev=%0d key=%0d mode=%0d pic=%0d digits=%0d, got ev=%0d key=%0d mode=%0d pic=%0d digits=%0d",
							want.ev, want.key, want.mode, want.pic, want.digits,
							got.ev, got.key, got.mode, got.pic, got.digits);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("debounced_keypad_code_lock_core: mismatch");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_bounce();
		test_latched_key();
		test_special_keys();
		test_code_match();
		test_zero_timers();
		test_max_timers();
		test_backpressure();
		test_random();
		wait_drained();
		if (mismatches == 0 && pending_status.size() == 0) begin
			$display("debounced_keypad_code_lock_core: match");
		end else begin
			$display("debounced_keypad_code_lock_core: mismatch");
		end
		$finish;
	end

endmodule
